// ===== hdl/pscl_pkg.sv =====
// Shared types and constants for the per-source connection limiter.
package pscl_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 9;
  localparam int CFG_W   = 16;
  localparam int ID_W    = 8;

  // Counts saturate here.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd256;

  // Configuration register indexes.
  localparam logic CFG_MAX_TOTAL      = 1'b0;
  localparam logic CFG_MAX_PER_SOURCE = 1'b1;

  // Event codes.
  localparam logic MODE_CONNECT    = 1'b0;
  localparam logic MODE_DISCONNECT = 1'b1;

  typedef enum logic [2:0] {
    STAT_ADMITTED   = 3'd0,
    STAT_TOTAL_OVER = 3'd1,
    STAT_SRC_OVER   = 3'd2,
    STAT_RELEASED   = 3'd3,
    STAT_UNKNOWN_ID = 3'd4,
    STAT_TABLE_FULL = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CONN,
    ST_DSLOT,
    ST_DROW
  } state_t;

  // One way of a bucket row.
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } way_t;

  // Lookup summary from the row update unit.
  typedef struct packed {
    logic               hit;
    logic               full;
    logic               sat;
    logic [COUNT_W-1:0] source;
  } row_res_t;

endpackage

// ===== hdl/pscl_ram.sv =====
// Simple dual-port synchronous RAM, registered read.
module pscl_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pscl_row_update.sv =====
// Bucket row lookup and count update for connect and disconnect.
module pscl_row_update #(
  parameter int WAYS = 4
) (
  input  logic                          op_disc,
  input  logic [pscl_pkg::KEY_W-1:0]    key,
  input  pscl_pkg::way_t [WAYS-1:0]     row_in,
  output pscl_pkg::way_t [WAYS-1:0]     row_out,
  output pscl_pkg::row_res_t            res
);
  import pscl_pkg::*;

  localparam int WI = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic          hit, fre;
  logic [WI-1:0] hit_w, free_w;
  logic [COUNT_W-1:0] cnt;

  // Lowest matching way and lowest free way.
  always_comb begin
    hit    = 1'b0;
    fre    = 1'b0;
    hit_w  = '0;
    free_w = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_in[w].valid && row_in[w].key == key) begin
        hit   = 1'b1;
        hit_w = WI'(w);
      end
      if (!row_in[w].valid) begin
        fre    = 1'b1;
        free_w = WI'(w);
      end
    end
  end

  always_comb begin
    row_out    = row_in;
    res        = '0;
    res.hit    = hit;
    cnt        = row_in[hit_w].count;
    if (!op_disc) begin
      if (hit) begin
        if (cnt >= COUNT_MAX) begin
          res.sat = 1'b1;
        end else begin
          cnt = cnt + 1'b1;
        end
        row_out[hit_w].count = cnt;
        res.source           = cnt;
      end else if (fre) begin
        row_out[free_w].valid = 1'b1;
        row_out[free_w].key   = key;
        row_out[free_w].count = COUNT_W'(1);
        res.source            = COUNT_W'(1);
      end else begin
        res.full = 1'b1;
      end
    end else if (hit) begin
      if (cnt != '0) begin
        cnt = cnt - 1'b1;
      end
      row_out[hit_w].count = cnt;
      if (cnt == '0) begin
        row_out[hit_w].valid = 1'b0;
      end
      res.source = cnt;
    end
  end

endmodule

// ===== hdl/per_source_connection_limiter.sv =====
// Top level: per-source connection limiter with hashed count table.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid/in_ready, mode, src_addr, conn_id | in
//  out     | out_valid/out_ready, status, total_now,    | out
//          | source_now                                 |
//  cfg     | cfg_we, cfg_index, cfg_wdata               | in
//
// Connect reads the bucket row, then updates and writes it back; disconnect
// reads the slot, then, unless the id is unknown, the bucket row, then updates.
// The single read port per table memory sets this order of steps.
// After reset a clearing pass zeroes both memories; no transaction is
// accepted during it.
// A finished result waits in the output register; a new transaction is taken
// while it waits, and the next result stalls only until that register frees.
// ADDR_BUCKETS and CONN_SLOTS must be powers of two (index = low address bits); the block does not check this.
module per_source_connection_limiter #(
  parameter int ADDR_BUCKETS = 256,
  parameter int BUCKET_WAYS  = 4,
  parameter int CONN_SLOTS   = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [pscl_pkg::KEY_W-1:0]    src_addr,
  input  logic [pscl_pkg::ID_W-1:0]     conn_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [pscl_pkg::COUNT_W-1:0]  total_now,
  output logic [pscl_pkg::COUNT_W-1:0]  source_now,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [pscl_pkg::CFG_W-1:0]    cfg_wdata
);
  import pscl_pkg::*;

  localparam int BB        = $clog2(ADDR_BUCKETS);
  localparam int SB        = $clog2(CONN_SLOTS);
  localparam int CLR_DEPTH = (ADDR_BUCKETS > CONN_SLOTS) ? ADDR_BUCKETS : CONN_SLOTS;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int ROW_W     = BUCKET_WAYS * $bits(way_t);
  localparam int SLOT_W    = KEY_W + 1;

  // Config registers
  logic [CFG_W-1:0] max_total, max_per_source;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_total      <= '0;
      max_per_source <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MAX_TOTAL) begin
        max_total <= cfg_wdata;
      end else begin
        max_per_source <= cfg_wdata;
      end
    end
  end

  // Control state
  state_t             state, state_next;
  logic [CLR_W-1:0]   clr_cnt;
  logic [COUNT_W-1:0] total_count, total_next;
  logic               produce;

  // Held transaction
  logic [KEY_W-1:0]   item_addr;
  logic [SB-1:0]      item_slot;

  // Slot index from conn_id (modulo CONN_SLOTS)
  logic [SB+ID_W-1:0] id_ext;
  logic [SB-1:0]      in_slot;
  assign id_ext  = {{SB{1'b0}}, conn_id};
  assign in_slot = id_ext[SB-1:0];

  // Clear indexes
  logic [SB+CLR_W-1:0] clr_ext_s;
  logic [BB+CLR_W-1:0] clr_ext_b;
  assign clr_ext_s = {{SB{1'b0}}, clr_cnt};
  assign clr_ext_b = {{BB{1'b0}}, clr_cnt};

  // Memories
  logic              slot_we, row_we;
  logic [SB-1:0]     slot_waddr, slot_raddr;
  logic [BB-1:0]     row_waddr, row_raddr;
  logic [SLOT_W-1:0] slot_wdata, slot_rdata;
  logic [ROW_W-1:0]  row_wdata, row_rdata;

  pscl_ram #(.DEPTH(CONN_SLOTS), .WIDTH(SLOT_W)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  pscl_ram #(.DEPTH(ADDR_BUCKETS), .WIDTH(ROW_W)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // Row update unit
  way_t [BUCKET_WAYS-1:0] row_in, row_out;
  row_res_t               res;

  assign row_in = row_rdata;

  pscl_row_update #(.WAYS(BUCKET_WAYS)) u_row_update (
    .op_disc (state == ST_DROW),
    .key     (item_addr),
    .row_in  (row_in),
    .row_out (row_out),
    .res     (res)
  );

  // Output register is free when empty or being drained this cycle.
  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Read addresses track the held transaction so read data stays put while
  // the result stalls.
  always_comb begin
    slot_raddr = item_slot;
    row_raddr  = item_addr[BB-1:0];
    if (state == ST_IDLE) begin
      slot_raddr = in_slot;
      row_raddr  = src_addr[BB-1:0];
    end else if (state == ST_DSLOT) begin
      row_raddr = slot_rdata[BB-1:0];
    end
  end

  // Limit checks for connect
  logic               tot_sat;
  logic [COUNT_W-1:0] tot_inc, tot_dec;
  status_t            conn_status;

  assign tot_sat = (total_count >= COUNT_MAX);
  assign tot_inc = tot_sat ? total_count : total_count + 1'b1;
  assign tot_dec = (total_count != '0) ? total_count - 1'b1 : total_count;

  always_comb begin
    if (res.full) begin
      conn_status = STAT_TABLE_FULL;
    end else if (tot_sat ||
                 (max_total != '0 && CFG_W'(tot_inc) > max_total)) begin
      conn_status = STAT_TOTAL_OVER;
    end else if (res.sat ||
                 (max_per_source != '0 && CFG_W'(res.source) > max_per_source)) begin
      conn_status = STAT_SRC_OVER;
    end else begin
      conn_status = STAT_ADMITTED;
    end
  end

  // Sequencer
  status_t            res_status;
  logic [COUNT_W-1:0] res_source;

  always_comb begin
    state_next = state;
    produce    = 1'b0;
    total_next = total_count;
    res_status = STAT_ADMITTED;
    res_source = '0;
    slot_we    = 1'b0;
    slot_waddr = item_slot;
    slot_wdata = {1'b1, item_addr};
    row_we     = 1'b0;
    row_waddr  = item_addr[BB-1:0];
    row_wdata  = row_out;
    unique case (state)
      ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_ext_s[SB-1:0];
        slot_wdata = '0;
        row_we     = 1'b1;
        row_waddr  = clr_ext_b[BB-1:0];
        row_wdata  = '0;
        if (clr_cnt == CLR_W'(CLR_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (mode == MODE_CONNECT) ? ST_CONN : ST_DSLOT;
        end
      end
      ST_CONN: begin
        if (out_free) begin
          produce    = 1'b1;
          total_next = tot_inc;
          res_status = conn_status;
          res_source = res.source;
          slot_we    = 1'b1;
          row_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DSLOT: begin
        if (!slot_rdata[KEY_W]) begin
          if (out_free) begin
            produce    = 1'b1;
            total_next = tot_dec;
            res_status = STAT_UNKNOWN_ID;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_DROW;
        end
      end
      ST_DROW: begin
        if (out_free) begin
          produce    = 1'b1;
          total_next = tot_dec;
          res_status = STAT_RELEASED;
          res_source = res.source;
          slot_we    = 1'b1;
          slot_wdata = '0;
          row_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      total_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      total_count <= total_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (produce) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item_addr <= src_addr;
      item_slot <= in_slot;
    end else if (state == ST_DSLOT) begin
      item_addr <= slot_rdata[KEY_W-1:0];
    end
    if (produce) begin
      status     <= res_status;
      total_now  <= total_next;
      source_now <= res_source;
    end
  end

  // Checks
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total_count <= COUNT_MAX)
    else $error("total count above saturation");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready)
    else $error("accept during clearing pass");

  a_connect_path: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode == MODE_CONNECT |=> state == ST_CONN)
    else $error("connect did not enter update state");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) != ST_IDLE && $past(state) != ST_CLEAR)
    else $error("result without transaction in flight");

endmodule

// ===== test/tb.sv =====
// Testbench for the per-source connection limiter: directed and random traffic.
`timescale 1ns / 1ps

module tb;
  import pscl_pkg::*;

  localparam int BUCKETS = 256;
  localparam int WAYS    = 4;
  localparam int SLOTS   = 256;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = MODE_CONNECT;
  logic [KEY_W-1:0] src_addr = '0;
  logic [ID_W-1:0] conn_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [COUNT_W-1:0] total_now;
  logic [COUNT_W-1:0] source_now;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_MAX_TOTAL;
  logic [CFG_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  per_source_connection_limiter DUT (.*);

  // Predictor state: limits, running total, hashed address table, slot table.
  logic [CFG_W-1:0]   lim_total, lim_source;
  logic [COUNT_W-1:0] open_total;
  logic [KEY_W-1:0]   tbl_key [BUCKETS*WAYS];
  logic [COUNT_W-1:0] tbl_count [BUCKETS*WAYS];
  logic               tbl_used [BUCKETS*WAYS];
  logic [KEY_W-1:0]   id_addr [SLOTS];
  logic               id_used [SLOTS];

  typedef struct packed {
    status_t            st;
    logic [COUNT_W-1:0] tot;
    logic [COUNT_W-1:0] src;
  } verdict_t;

  verdict_t pending_verdicts[$];
  int errors = 0;
  bit no_idle = 1'b0;     // disables random gaps on both sides

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $time, what);
    errors++;
  endtask

  function automatic int lookup_entry(input logic [KEY_W-1:0] a);
    int base;
    base = (a % BUCKETS) * WAYS;
    for (int w = 0; w < WAYS; w++)
      if (tbl_used[base+w] && tbl_key[base+w] == a) return base + w;
    return -1;
  endfunction

  // Computes the verdict of one event and advances the predictor state.
  function automatic verdict_t admit_event(input logic m, input logic [KEY_W-1:0] a,
                                           input logic [ID_W-1:0] id);
    verdict_t v;
    int e, base;
    logic tsat, ssat, full;
    v.src = '0;
    tsat = 1'b0; ssat = 1'b0; full = 1'b0;
    if (m == MODE_CONNECT) begin
      tsat = (open_total >= COUNT_MAX);
      if (!tsat) open_total++;
      e = lookup_entry(a);
      if (e >= 0) begin
        if (tbl_count[e] >= COUNT_MAX) ssat = 1'b1;
        else tbl_count[e]++;
        v.src = tbl_count[e];
      end else begin
        base = (a % BUCKETS) * WAYS;
        for (int w = 0; w < WAYS; w++)
          if (e < 0 && !tbl_used[base+w]) e = base + w;
        if (e >= 0) begin
          tbl_used[e] = 1'b1; tbl_key[e] = a; tbl_count[e] = COUNT_W'(1);
          v.src = COUNT_W'(1);
        end else begin
          full = 1'b1;
        end
      end
      id_addr[id] = a;
      id_used[id] = 1'b1;
      if (full) v.st = STAT_TABLE_FULL;
      else if (tsat || (lim_total != 0 && open_total > lim_total)) v.st = STAT_TOTAL_OVER;
      else if (ssat || (lim_source != 0 && v.src > lim_source)) v.st = STAT_SRC_OVER;
      else v.st = STAT_ADMITTED;
    end else begin
      if (open_total > 0) open_total--;
      if (!id_used[id]) begin
        v.st = STAT_UNKNOWN_ID;
      end else begin
        e = lookup_entry(id_addr[id]);
        id_used[id] = 1'b0;
        v.st = STAT_RELEASED;
        if (e >= 0) begin
          if (tbl_count[e] > 0) tbl_count[e]--;
          v.src = tbl_count[e];
          if (v.src == 0) tbl_used[e] = 1'b0;
        end
      end
    end
    v.tot = open_total;
    return v;
  endfunction

  task automatic write_limit(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_TOTAL) lim_total = val;
    else lim_source = val;
    @(posedge clk);
  endtask

  // Sends one event; prediction is made when the transaction is accepted.
  task automatic send_event(input logic m, input logic [KEY_W-1:0] a,
                            input logic [ID_W-1:0] id);
    while (!no_idle && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    src_addr <= a;
    conn_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_verdicts.push_back(admit_event(m, a, id));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          exp_v = pending_verdicts.pop_front();
          if (status !== exp_v.st)
            report_mismatch($sformatf("status %0d exp %0d", status, exp_v.st));
          if (total_now !== exp_v.tot)
            report_mismatch($sformatf("total_now %0d exp %0d", total_now, exp_v.tot));
          if (source_now !== exp_v.src)
            report_mismatch($sformatf("source_now %0d exp %0d", source_now, exp_v.src));
        end
      end
      out_ready <= no_idle || ($urandom_range(99) >= 11);
    end
  end

  // Directed: field extremes, full bucket, unknown id, reused id.
  task automatic test_directed;
    send_event(MODE_DISCONNECT, 32'h0, 8'h00);          // unknown id, total stays 0
    send_event(MODE_CONNECT, 32'hFFFF_FFFF, 8'hFF);
    send_event(MODE_CONNECT, 32'h0000_0000, 8'h00);
    send_event(MODE_CONNECT, 32'hFFFF_FFFF, 8'h01);
    send_event(MODE_CONNECT, 32'h1234_5600, 8'h00);     // reused id
    send_event(MODE_DISCONNECT, 32'hFFFF_FFFF, 8'hFF);
    send_event(MODE_DISCONNECT, 32'h0, 8'h00);
    // five addresses on bucket 0x11: the fifth meets a full bucket
    for (int i = 0; i < 5; i++)
      send_event(MODE_CONNECT, {i[23:0], 8'h11}, 8'(8'h10 + i));
    send_event(MODE_DISCONNECT, 32'h0, 8'h14);          // recorded, no table entry
    for (int i = 0; i < 4; i++) send_event(MODE_DISCONNECT, 32'h0, 8'(8'h10 + i));
    send_event(MODE_DISCONNECT, 32'h0, 8'h01);
    send_event(MODE_DISCONNECT, 32'h0, 8'h01);          // already released
    drain();
  endtask

  // Pushes total and one address past 256 to reach both saturation cases.
  task automatic test_saturation;
    write_limit(CFG_MAX_TOTAL, 16'd0);
    write_limit(CFG_MAX_PER_SOURCE, 16'd0);
    for (int i = 0; i < 262; i++) send_event(MODE_CONNECT, 32'hA5A5_5A5A, i[7:0]);
    for (int i = 0; i < 262; i++) send_event(MODE_DISCONNECT, 32'h0, i[7:0]);
    // total may be left nonzero by reused ids; clear it with unknown disconnects
    for (int i = 0; i < 8; i++) send_event(MODE_DISCONNECT, 32'h0, 8'h00);
    drain();
  endtask

  // Random sessions under one pair of limits, partly over a small address pool.
  task automatic test_random(input int n, input logic [CFG_W-1:0] lt,
                             input logic [CFG_W-1:0] ls);
    logic [KEY_W-1:0] a;
    int id;
    write_limit(CFG_MAX_TOTAL, lt);
    write_limit(CFG_MAX_PER_SOURCE, ls);
    for (int i = 0; i < n; i++) begin
      id = $urandom_range(255);
      if ($urandom_range(99) < 10) begin
        send_event(1'($urandom_range(1)), $urandom(), id[7:0]);    // noise
      end else if (!id_used[id] && $urandom_range(99) < 85) begin
        case ($urandom_range(2))
          0: a = {24'($urandom_range(3)), 8'($urandom_range(3))};  // few buckets
          1: a = {8'($urandom_range(15)), 24'h0};                   // crowded bucket 0
          default: a = $urandom();
        endcase
        send_event(MODE_CONNECT, a, id[7:0]);
      end else begin
        send_event(MODE_DISCONNECT, $urandom(), id[7:0]);
      end
    end
    drain();
  endtask

  initial begin
    lim_total = '0; lim_source = '0; open_total = '0;
    for (int i = 0; i < BUCKETS*WAYS; i++) tbl_used[i] = 1'b0;
    for (int i = 0; i < SLOTS; i++) id_used[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_random(400, 16'd0, 16'd0);
    no_idle = 1'b1;
    test_random(300, 16'd40, 16'd3);
    no_idle = 1'b0;
    test_random(250, 16'd1, 16'd1);
    test_random(250, 16'hFFFF, 16'hFFFF);
    test_random(150, 16'd100, 16'd2);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
